// File: rtl/skf_pkg.sv
// Package for the scalar Kalman filter unit: default widths, reset values,
// register indexes, controller states and the controller/datapath interface types.
// It has no dependencies.
package skf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int GAIN_BITS      = 16;
    localparam int DIV_STEPS      = GAIN_BITS + 1;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W     = 1;

    localparam logic [63:0] PROC_NOISE_RESET = 64'd655;
    localparam logic [63:0] MEAS_NOISE_RESET = 64'd65536;

    localparam logic [CFG_ADDR_W-1:0] CFG_PROC_NOISE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_NOISE = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DEN,
        ST_DIV,
        ST_MUL_GAIN,
        ST_MUL_COV,
        ST_COMMIT
    } skf_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic den;
        logic div_step;
        logic mul_gain;
        logic mul_cov;
        logic commit;
    } skf_cmd_t;

    typedef struct packed {
        logic out_free;
    } skf_status_t;

endpackage

// File: rtl/skf_controller.sv
// Sequencing state machine of the scalar Kalman filter unit.
// Depends on skf_pkg; drives the commands of skf_datapath.
module skf_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  skf_pkg::skf_status_t status,
    output skf_pkg::skf_cmd_t   cmd
);
    import skf_pkg::*;

    skf_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DEN;
            end
            ST_DEN: begin
                cmd.den    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN: begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_MUL_COV;
            end
            ST_MUL_COV: begin
                cmd.mul_cov = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/skf_datapath.sv
// Datapath of the scalar Kalman filter unit: configuration registers, filter state,
// restoring gain divider, one shared multiplier and the output register.
// Depends on skf_pkg; commanded by skf_controller.
module skf_datapath #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
    parameter int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((DATA_WIDTH + skf_pkg::GAIN_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [skf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_WIDTH-1:0]         cfg_wdata,
    input  logic [IN_W-1:0]               s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,
    input  skf_pkg::skf_cmd_t             cmd,
    output skf_pkg::skf_status_t          status
);
    import skf_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int PROD_W = DW + GAIN_BITS + 2;

    logic [DW-1:0]           q_noise_reg, r_noise_reg;
    logic [DW-1:0]           est_reg, cov_reg;
    logic [DW-1:0]           sample_reg;
    logic [DW-1:0]           p_reg;
    logic [DW:0]             diff_reg;
    logic [DW:0]             mag_reg;
    logic                    neg_reg;
    logic [DW:0]             den_reg;
    logic [DW+1:0]           rem_reg;
    logic [GAIN_BITS:0]      quo_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [DW-1:0]           out_est_reg;
    logic [GAIN_BITS-1:0]    out_gain_reg;
    logic                    m_tvalid_reg;

    logic [DW:0]             cov_sum;
    logic [DW-1:0]           p_next;
    logic [DW:0]             diff_next;
    logic [DW+1:0]           div_rem;
    logic                    div_bit;
    logic [GAIN_BITS-1:0]    gain;
    logic [DW:0]             mul_a;
    logic [GAIN_BITS:0]      mul_b;
    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W-1:0]       prod_rnd;
    logic [DW:0]             step;
    logic [DW:0]             est_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_noise_reg <= DW'(PROC_NOISE_RESET);
            r_noise_reg <= DW'(MEAS_NOISE_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PROC_NOISE: q_noise_reg <= cfg_wdata;
                CFG_MEAS_NOISE: r_noise_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cov_sum   = {1'b0, cov_reg} + {1'b0, q_noise_reg};
    assign p_next    = cov_sum[DW] ? {DW{1'b1}} : cov_sum[DW-1:0];
    assign diff_next = {sample_reg[DW-1], sample_reg} - {est_reg[DW-1], est_reg};

    assign div_bit = (rem_reg >= {1'b0, den_reg});
    assign div_rem = div_bit ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    assign gain = quo_reg[GAIN_BITS] ? {GAIN_BITS{1'b1}} : quo_reg[GAIN_BITS-1:0];

    assign mul_a     = cmd.mul_gain ? mag_reg : {1'b0, p_reg};
    assign mul_b     = cmd.mul_gain ? {1'b0, gain}
                                    : ({1'b1, {GAIN_BITS{1'b0}}} - {1'b0, gain});
    assign prod_next = {{(GAIN_BITS + 1){1'b0}}, mul_a} * {{(DW + 1){1'b0}}, mul_b};

    assign prod_rnd = prod_reg + (PROD_W'(1) << (GAIN_BITS - 1));
    assign step     = prod_rnd[DW+GAIN_BITS:GAIN_BITS];
    assign est_sum  = neg_reg ? ({est_reg[DW-1], est_reg} - step)
                              : ({est_reg[DW-1], est_reg} + step);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_tdata[DW-1:0];
        end
        if (cmd.prep) begin
            p_reg    <= p_next;
            diff_reg <= diff_next;
        end
        if (cmd.den) begin
            den_reg <= {1'b0, p_reg} + {1'b0, r_noise_reg};
            rem_reg <= {2'b00, p_reg};
            neg_reg <= diff_reg[DW];
            mag_reg <= diff_reg[DW] ? (~diff_reg + 1'b1) : diff_reg;
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= {div_rem[DW:0], 1'b0};
            quo_reg <= {quo_reg[GAIN_BITS-1:0], div_bit};
        end
        if (cmd.mul_gain || cmd.mul_cov) begin
            prod_reg <= prod_next;
        end
        if (cmd.commit) begin
            out_est_reg  <= est_reg;
            out_gain_reg <= gain;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg      <= '0;
            cov_reg      <= DW'(1) << FRAC_BITS;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.mul_cov) begin
                est_reg <= est_sum[DW-1:0];
            end
            if (cmd.commit) begin
                cov_reg      <= prod_reg[DW+GAIN_BITS-1:GAIN_BITS];
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = OUT_W'({out_gain_reg, out_est_reg});
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

// File: rtl/scalar_kalman_filter_unit.sv
// Scalar Kalman filter unit: one signed fixed-point sample in, one filtered estimate
// and the gain used out. From acceptance until the unit is ready again, a sample
// passes through an accept state, setup states that form the predicted covariance
// and the divisor, 17 iterations of the restoring divider that makes the 16-bit
// gain, the single shared multiplier (estimate step, then covariance update) and a
// commit state that loads the output register. The commit waits while the previous
// result is still held in the output register. The user must write the noise
// registers through the cfg port only while no sample is in flight; the unit itself
// does not enforce this. Depends on skf_pkg, skf_controller and skf_datapath.
module scalar_kalman_filter_unit #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
    parameter int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((DATA_WIDTH + skf_pkg::GAIN_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [skf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_WIDTH-1:0]          cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: sample.
    input  logic [IN_W-1:0]                s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: estimate, gain.
    output logic [OUT_W-1:0]               m_tdata
);
    import skf_pkg::*;

    skf_cmd_t    cmd;
    skf_status_t status;

    skf_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skf_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (cmd.prep && !s_tready))
        else $error("accepted transaction did not start the update sequence");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> status.out_free)
        else $error("result committed while the output register was occupied");

    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_gain |=> cmd.mul_cov)
        else $error("covariance multiply did not follow the gain multiply");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed result is not presented on the output");
`endif

endmodule
